// ===== src/vtu_pkg.sv =====
// Package for the vertex transform unit: shared types, operation codes,
// and the CORDIC angle and gain tables. No dependencies.
package vtu_pkg;

    localparam logic [2:0] FUNC_TRANSLATE = 3'd0;
    localparam logic [2:0] FUNC_SCALE     = 3'd1;
    localparam logic [2:0] FUNC_ROT_X     = 3'd2;
    localparam logic [2:0] FUNC_ROT_Y     = 3'd3;
    localparam logic [2:0] FUNC_ROT_Z     = 3'd4;
    localparam logic [2:0] FUNC_ROT_XYZ   = 3'd5;

    localparam int MaxStages = 24;

    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

    // round(2^54 / TWO_PI_Q30): angle * INV_TWO_PI / 2^40 estimates the turn count
    localparam logic signed [23:0] INV_TWO_PI  = 24'sd2670177;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [32:0] trig_t;
    typedef logic signed [35:0] ang_t;

    typedef struct packed {
        logic [2:0] func;
        coord_t     x;
        coord_t     y;
        coord_t     z;
        coord_t     w;
        coord_t     a;
        coord_t     b;
        coord_t     c;
    } vtx_req_t;

    function automatic ang_t atan_q30(input int i);
        case (i)
            0:  atan_q30 = 36'sd843314857;
            1:  atan_q30 = 36'sd497837829;
            2:  atan_q30 = 36'sd263043837;
            3:  atan_q30 = 36'sd133525159;
            4:  atan_q30 = 36'sd67021687;
            5:  atan_q30 = 36'sd33543516;
            6:  atan_q30 = 36'sd16775851;
            7:  atan_q30 = 36'sd8388437;
            8:  atan_q30 = 36'sd4194283;
            9:  atan_q30 = 36'sd2097149;
            10: atan_q30 = 36'sd1048576;
            11: atan_q30 = 36'sd524288;
            12: atan_q30 = 36'sd262144;
            13: atan_q30 = 36'sd131072;
            14: atan_q30 = 36'sd65536;
            15: atan_q30 = 36'sd32768;
            16: atan_q30 = 36'sd16384;
            17: atan_q30 = 36'sd8192;
            18: atan_q30 = 36'sd4096;
            19: atan_q30 = 36'sd2048;
            20: atan_q30 = 36'sd1024;
            21: atan_q30 = 36'sd512;
            22: atan_q30 = 36'sd256;
            default: atan_q30 = 36'sd128;
        endcase
    endfunction

    function automatic trig_t gain_q30(input int n);
        case (n)
            8:  gain_q30 = 33'sd652039507;
            9:  gain_q30 = 33'sd652034532;
            10: gain_q30 = 33'sd652033289;
            11: gain_q30 = 33'sd652032978;
            12: gain_q30 = 33'sd652032900;
            13: gain_q30 = 33'sd652032881;
            14: gain_q30 = 33'sd652032876;
            default: gain_q30 = 33'sd652032874;
        endcase
    endfunction

endpackage

// ===== src/vtu_cordic.sv =====
// Pipelined angle reduction and CORDIC sine/cosine for three angles in parallel.
// Depends on vtu_pkg. One register stage per CORDIC iteration plus reduction.
module vtu_cordic
    import vtu_pkg::*;
#(
    parameter int STAGES = 16,
    parameter int WB     = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  coord_t        ang   [3],
    input  logic [WB-1:0] side_in,
    output trig_t         sin_o [3],
    output trig_t         cos_o [3],
    output logic [WB-1:0] side_out
);

    localparam int N = (STAGES < 8) ? 8 : ((STAGES > 24) ? 24 : STAGES);

    // angle*2^14 reduced mod 2pi: quotient by reciprocal estimate then fix
    logic signed [45:0] t_reg [3];
    logic signed [15:0] q_reg [3];
    logic [WB-1:0]      s0_reg;
    ang_t               r1_reg [3];
    logic [WB-1:0]      s1_reg;

    ang_t               cz_reg [N+1][3];
    logic signed [34:0] cx_reg [N+1][3];
    logic signed [34:0] cy_reg [N+1][3];
    logic               ng_reg [N+1][3];
    logic [WB-1:0]      cs_reg [N+1];

    // estimate q = floor(ang * INV_TWO_PI / 2^40), off by at most one
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [55:0] prod;
                prod = 56'(ang[k]) * 56'(INV_TWO_PI);
                t_reg[k] <= 46'(ang[k]) <<< 14;
                q_reg[k] <= 16'(prod >>> 40);
            end
            s0_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [47:0] r;
                r = 48'(t_reg[k]) - 48'(q_reg[k]) * 48'(TWO_PI_Q30);
                if (r < 0)
                    r = r + 48'(TWO_PI_Q30);
                else if (r >= 48'(TWO_PI_Q30))
                    r = r - 48'(TWO_PI_Q30);
                r1_reg[k] <= ang_t'(r);
            end
            s1_reg <= s0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ang_t r;
                logic ng;
                r  = r1_reg[k];
                ng = 1'b0;
                if (r > PI_Q30) r = r - TWO_PI_Q30;
                if (r > HALF_PI_Q30)
                begin
                    r  = r - PI_Q30;
                    ng = 1'b1;
                end
                else if (r < -HALF_PI_Q30)
                begin
                    r  = r + PI_Q30;
                    ng = 1'b1;
                end
                cz_reg[0][k] <= r;
                cx_reg[0][k] <= 35'(gain_q30(N));
                cy_reg[0][k] <= '0;
                ng_reg[0][k] <= ng;
            end
            cs_reg[0] <= s1_reg;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_it
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (cz_reg[i][k] >= 0)
                    begin
                        cx_reg[i+1][k] <= cx_reg[i][k] - (cy_reg[i][k] >>> i);
                        cy_reg[i+1][k] <= cy_reg[i][k] + (cx_reg[i][k] >>> i);
                        cz_reg[i+1][k] <= cz_reg[i][k] - atan_q30(i);
                    end
                    else
                    begin
                        cx_reg[i+1][k] <= cx_reg[i][k] + (cy_reg[i][k] >>> i);
                        cy_reg[i+1][k] <= cy_reg[i][k] - (cx_reg[i][k] >>> i);
                        cz_reg[i+1][k] <= cz_reg[i][k] + atan_q30(i);
                    end
                    ng_reg[i+1][k] <= ng_reg[i][k];
                end
                cs_reg[i+1] <= cs_reg[i];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cos_o[k] = ng_reg[N][k] ? trig_t'(-cx_reg[N][k]) : trig_t'(cx_reg[N][k]);
            sin_o[k] = ng_reg[N][k] ? trig_t'(-cy_reg[N][k]) : trig_t'(cy_reg[N][k]);
        end
    end

    assign side_out = cs_reg[N];

    logic unused_rst;
    assign unused_rst = rst_n;

endmodule

// ===== src/vertex_transform_unit.sv =====
// Vertex transform unit, top level: input side, trig pipeline, matrix stages,
// rounding, saturation and output register. Depends on vtu_pkg and vtu_cordic.
//
// One vertex per cycle, back to back, unless the output stalls. With N being
// CORDIC_STAGES clamped to 8..24, the stages are three angle reduction
// stages, N CORDIC iterations, then trig products, matrix entries, coordinate
// products and output register. A single stall signal freezes every stage, so
// while a finished result waits for the receiver no new request is taken.
module vertex_transform_unit
    import vtu_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,   // in_x, in_y, in_z, in_w, arg_a, arg_b, arg_c
    input  logic [2:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_x, out_y, out_z, out_w
    output logic         m_tuser    // overflow
);

    localparam int N   = (CORDIC_STAGES < 8) ? 8 : ((CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES);
    localparam int LAT = N + 3;
    localparam int RW  = $bits(vtx_req_t);

    logic     en;
    vtx_req_t req;
    coord_t   ang [3];
    trig_t    sn [3];
    trig_t    cs [3];
    logic [RW:0] side_o;
    vtx_req_t rq;
    logic     v1;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign req.func = s_tuser;
    assign req.x    = s_tdata[31:0];
    assign req.y    = s_tdata[63:32];
    assign req.z    = s_tdata[95:64];
    assign req.w    = s_tdata[127:96];
    assign req.a    = s_tdata[159:128];
    assign req.b    = s_tdata[191:160];
    assign req.c    = s_tdata[223:192];

    assign ang[0] = req.a;
    assign ang[1] = req.b;
    assign ang[2] = req.c;

    vtu_cordic #(.STAGES(N), .WB(RW + 1)) u_cordic
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ang      (ang),
        .side_in  ({s_tvalid, req}),
        .sin_o    (sn),
        .cos_o    (cs),
        .side_out (side_o)
    );

    // valid bits need reset; rebuild a reset-cleared valid chain alongside
    logic [LAT-1:0] vchain_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vchain_reg <= '0;
        else if (en) vchain_reg <= {vchain_reg[LAT-2:0], s_tvalid};
    end

    assign rq = vtx_req_t'(side_o[RW-1:0]);
    assign v1 = vchain_reg[LAT-1] & side_o[RW];

    // stage A: first trig products (rounded Q30)
    trig_t sa_reg, ca_reg, sb_reg, cb_reg, se_reg, ce_reg;
    trig_t cbce_reg, cbse_reg, sacb_reg, cacb_reg, sase_reg, case_reg, cace_reg, sace_reg;
    trig_t bd_reg, ad_reg;
    vtx_req_t ra_reg;
    logic va_reg;

    function automatic trig_t m30(input trig_t p, input trig_t q);
        logic signed [65:0] t;
        t = 66'(p) * 66'(q) + 66'sd536870912;
        return trig_t'(t >>> 30);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) va_reg <= 1'b0;
        else if (en) va_reg <= v1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ra_reg   <= rq;
            sa_reg   <= sn[0];
            ca_reg   <= cs[0];
            sb_reg   <= sn[1];
            cb_reg   <= cs[1];
            se_reg   <= sn[2];
            ce_reg   <= cs[2];
            cbce_reg <= m30(cs[1], cs[2]);
            cbse_reg <= m30(cs[1], sn[2]);
            sacb_reg <= m30(sn[0], cs[1]);
            cacb_reg <= m30(cs[0], cs[1]);
            sase_reg <= m30(sn[0], sn[2]);
            case_reg <= m30(cs[0], sn[2]);
            cace_reg <= m30(cs[0], cs[2]);
            sace_reg <= m30(sn[0], cs[2]);
            bd_reg   <= m30(sn[0], sn[1]);
            ad_reg   <= m30(cs[0], sn[1]);
        end
    end

    // stage B: matrix entries
    trig_t m_reg [9];
    vtx_req_t rb_reg;
    logic vb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vb_reg <= 1'b0;
        else if (en) vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rb_reg <= ra_reg;
            case (ra_reg.func)
                FUNC_ROT_X:
                begin
                    m_reg[0] <= 33'sd1073741824; m_reg[1] <= '0;      m_reg[2] <= '0;
                    m_reg[3] <= '0;      m_reg[4] <= ca_reg;  m_reg[5] <= trig_t'(-sa_reg);
                    m_reg[6] <= '0;      m_reg[7] <= sa_reg;  m_reg[8] <= ca_reg;
                end
                FUNC_ROT_Y:
                begin
                    m_reg[0] <= ca_reg;  m_reg[1] <= '0;      m_reg[2] <= sa_reg;
                    m_reg[3] <= '0;      m_reg[4] <= 33'sd1073741824; m_reg[5] <= '0;
                    m_reg[6] <= trig_t'(-sa_reg); m_reg[7] <= '0; m_reg[8] <= ca_reg;
                end
                FUNC_ROT_Z:
                begin
                    m_reg[0] <= ca_reg;  m_reg[1] <= trig_t'(-sa_reg); m_reg[2] <= '0;
                    m_reg[3] <= sa_reg;  m_reg[4] <= ca_reg;  m_reg[5] <= '0;
                    m_reg[6] <= '0;      m_reg[7] <= '0;      m_reg[8] <= 33'sd1073741824;
                end
                default:
                begin
                    m_reg[0] <= cbce_reg;
                    m_reg[1] <= trig_t'(-cbse_reg);
                    m_reg[2] <= sb_reg;
                    m_reg[3] <= m30(bd_reg, ce_reg) + case_reg;
                    m_reg[4] <= cace_reg - m30(bd_reg, se_reg);
                    m_reg[5] <= trig_t'(-sacb_reg);
                    m_reg[6] <= sase_reg - m30(ad_reg, ce_reg);
                    m_reg[7] <= m30(ad_reg, se_reg) + sace_reg;
                    m_reg[8] <= cacb_reg;
                end
            endcase
        end
    end

    // stage C: coordinate products; translate/scale share these multipliers
    logic signed [64:0] p_next [9];
    logic signed [64:0] p_reg [9];
    vtx_req_t rc_reg;
    logic vc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vc_reg <= 1'b0;
        else if (en) vc_reg <= vb_reg;
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++) p_next[k] = '0;
        case (rb_reg.func)
            FUNC_TRANSLATE:
            begin
                p_next[0] = 65'(rb_reg.a) * 65'(rb_reg.w);
                p_next[4] = 65'(rb_reg.b) * 65'(rb_reg.w);
                p_next[8] = 65'(rb_reg.c) * 65'(rb_reg.w);
            end
            FUNC_SCALE:
            begin
                p_next[0] = 65'(rb_reg.x) * 65'(rb_reg.a);
                p_next[4] = 65'(rb_reg.y) * 65'(rb_reg.b);
                p_next[8] = 65'(rb_reg.z) * 65'(rb_reg.c);
            end
            FUNC_ROT_X, FUNC_ROT_Y, FUNC_ROT_Z, FUNC_ROT_XYZ:
            begin
                p_next[0] = 65'(rb_reg.x) * 65'(m_reg[0]);
                p_next[1] = 65'(rb_reg.y) * 65'(m_reg[1]);
                p_next[2] = 65'(rb_reg.z) * 65'(m_reg[2]);
                p_next[3] = 65'(rb_reg.x) * 65'(m_reg[3]);
                p_next[4] = 65'(rb_reg.y) * 65'(m_reg[4]);
                p_next[5] = 65'(rb_reg.z) * 65'(m_reg[5]);
                p_next[6] = 65'(rb_reg.x) * 65'(m_reg[6]);
                p_next[7] = 65'(rb_reg.y) * 65'(m_reg[7]);
                p_next[8] = 65'(rb_reg.z) * 65'(m_reg[8]);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rc_reg <= rb_reg;
            for (int k = 0; k < 9; k++) p_reg[k] <= p_next[k];
        end
    end

    // stage D: sums and rounding, then saturate into output register
    logic signed [67:0] sum_next [3];
    logic signed [67:0] rr_next [3];
    logic [31:0] o_next [3];
    logic ovf_next;

    always_comb
    begin
        ovf_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            sum_next[k] = 68'(p_reg[3*k]) + 68'(p_reg[3*k+1]) + 68'(p_reg[3*k+2]);
            case (rc_reg.func)
                FUNC_TRANSLATE:
                    rr_next[k] = (sum_next[k] + (68'(k == 0 ? rc_reg.x :
                                  (k == 1 ? rc_reg.y : rc_reg.z)) <<< 16)
                                  + 68'sd32768) >>> 16;
                FUNC_SCALE:
                    rr_next[k] = (sum_next[k] + 68'sd32768) >>> 16;
                FUNC_ROT_X, FUNC_ROT_Y, FUNC_ROT_Z, FUNC_ROT_XYZ:
                    rr_next[k] = (sum_next[k] + 68'sd536870912) >>> 30;
                default:
                    rr_next[k] = 68'(k == 0 ? rc_reg.x : (k == 1 ? rc_reg.y : rc_reg.z));
            endcase
            if (rr_next[k] > 68'sd2147483647)
            begin
                o_next[k] = 32'h7FFFFFFF;
                ovf_next  = 1'b1;
            end
            else if (rr_next[k] < -68'sd2147483648)
            begin
                o_next[k] = 32'h80000000;
                ovf_next  = 1'b1;
            end
            else
            begin
                o_next[k] = rr_next[k][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m_tvalid <= 1'b0;
        else if (en) m_tvalid <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata <= {rc_reg.w, o_next[2], o_next[1], o_next[0]};
            m_tuser <= ovf_next;
        end
    end

endmodule
